// File: src/ksu_pkg.sv
// shared types, constants and saturation helpers for the scalar measurement update unit
package ksu_pkg;

	localparam int VAL_W  = 48;
	localparam int NIS_W  = 47;
	localparam int IN_IDX_W = 4;
	localparam int FUNC_W = 3;
	localparam int ACC_W  = 56;
	localparam int PROD_W = 96;
	localparam int HALF_W = 24;
	localparam int QUO_W  = 49;
	localparam int CNT_W  = 7;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [QUO_W-1:0] QUO_CAP = {1'b1, {(QUO_W-1){1'b0}}};

	typedef enum logic [FUNC_W-1:0] {
		FN_WR_COV  = 3'd0,
		FN_WR_MEAS = 3'd1,
		FN_WR_ERR  = 3'd2,
		FN_RD_COV  = 3'd3,
		FN_RD_ERR  = 3'd4,
		FN_UPDATE  = 3'd5
	} ksu_func_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OP_RD,
		ST_OP_END,
		ST_RD,
		ST_MUL1,
		ST_WAIT1,
		ST_MUL2,
		ST_WAIT2,
		ST_KR_RD,
		ST_KR_MUL,
		ST_KR_WAIT,
		ST_KG_RD,
		ST_KG_MUL,
		ST_KG_WAIT,
		ST_DIV,
		ST_DIV_WAIT,
		ST_NEXT,
		ST_RESULT
	} ksu_state_t;

	typedef enum logic [2:0] {
		PH_GAIN,
		PH_VAR,
		PH_KDIV,
		PH_ERR,
		PH_PROD,
		PH_COV,
		PH_NIS
	} ksu_phase_t;

	// saturate a wide accumulator to 48 bits signed
	function automatic val_t sat_acc(input acc_t v);
		val_t r;
		if (v > acc_t'(VAL_MAX)) r = VAL_MAX;
		else if (v < acc_t'(VAL_MIN)) r = VAL_MIN;
		else r = v[VAL_W-1:0];
		return r;
	endfunction

	// signed 48-bit value from a magnitude and a sign, saturated
	function automatic val_t sat_mag(input logic [PROD_W:0] m, input logic neg);
		val_t r;
		if (|m[PROD_W:VAL_W-1]) r = neg ? VAL_MIN : VAL_MAX;
		else if (neg) r = -$signed({1'b0, m[VAL_W-2:0]});
		else r = $signed({1'b0, m[VAL_W-2:0]});
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] mag(input val_t v);
		logic [VAL_W-1:0] r;
		r = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
		return r;
	endfunction

endpackage

// File: src/ksu_if.sv
// item channels of the scalar measurement update unit
interface ksu_in_if import ksu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [IN_IDX_W-1:0]  row_index;
	logic [IN_IDX_W-1:0]  col_index;
	logic signed [VAL_W-1:0] write_value;
	logic signed [VAL_W-1:0] meas_value;
	logic signed [VAL_W-1:0] predicted_value;
	logic [NIS_W-1:0]     noise_var;

	modport source (output valid, func, row_index, col_index, write_value, meas_value,
		predicted_value, noise_var, input ready);
	modport sink (input valid, func, row_index, col_index, write_value, meas_value,
		predicted_value, noise_var, output ready);
endinterface

interface ksu_out_if import ksu_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] read_data;
	logic [NIS_W-1:0]        nis;
	logic                    var_floored;
	logic                    nis_saturated;

	modport source (output valid, read_data, nis, var_floored, nis_saturated, input ready);
	modport sink (input valid, read_data, nis, var_floored, nis_saturated, output ready);
endinterface

// File: src/ksu_ram.sv
// generic single-write, single-read ram with registered read data
module ksu_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/ksu_mul.sv
// shared fixed point multiplier, one 24x24 partial product per cycle, rounded result
module ksu_mul import ksu_pkg::*; #(
	parameter int FRAC_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  val_t              a,
	input  val_t              b,
	output logic              done,
	output logic [PROD_W-1:0] prod,
	output val_t              qres
);
	logic [VAL_W-1:0]    am_q, bm_q;
	logic                neg_q;
	logic [1:0]          step_q;
	logic                busy_q, done_q;
	logic [PROD_W-1:0]   prod_q;
	logic [HALF_W-1:0]   opa, opb;
	logic [2*HALF_W-1:0] pp;
	logic [PROD_W-1:0]   pp_sh;
	logic [PROD_W:0]     rsum, rmag;

	always_comb begin
		opa = step_q[1] ? am_q[VAL_W-1:HALF_W] : am_q[HALF_W-1:0];
		opb = step_q[0] ? bm_q[VAL_W-1:HALF_W] : bm_q[HALF_W-1:0];
		pp = opa * opb;
		case (step_q)
			2'd0:    pp_sh = PROD_W'(pp);
			2'd3:    pp_sh = PROD_W'(pp) << (2 * HALF_W);
			default: pp_sh = PROD_W'(pp) << HALF_W;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			am_q   <= mag(a);
			bm_q   <= mag(b);
			neg_q  <= a[VAL_W-1] ^ b[VAL_W-1];
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= prod_q + pp_sh;
		end
	end

	// round half away from zero on the magnitude, then saturate
	assign rsum = {1'b0, prod_q} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
	assign rmag = rsum >> FRAC_BITS;
	assign qres = sat_mag(rmag, neg_q);
	assign prod = prod_q;
	assign done = done_q;
endmodule

// File: src/ksu_div.sv
// restoring divider, one quotient bit per cycle, quotient capped and rounded
module ksu_div import ksu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [VAL_W-1:0]  divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quot
);
	logic [PROD_W-1:0] dvd_q;
	logic [VAL_W-1:0]  d_q, rem_q, rem_n;
	logic [QUO_W-1:0]  q_q, q_n;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, fin_q, done_q;
	logic [VAL_W:0]    rem_sh;
	logic              ge;
	logic [QUO_W:0]    q_sh;
	logic              round_up;

	always_comb begin
		rem_sh = {rem_q, dvd_q[PROD_W-1]};
		ge = rem_sh >= {1'b0, d_q};
		rem_n = ge ? VAL_W'(rem_sh - {1'b0, d_q}) : rem_sh[VAL_W-1:0];
		q_sh = {q_q, ge};
		q_n = (q_sh > (QUO_W+1)'(QUO_CAP)) ? QUO_CAP : q_sh[QUO_W-1:0];
		round_up = (q_q < QUO_CAP) && ({rem_q, 1'b0} >= {1'b0, d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_n;
			q_q   <= q_n;
		end else if (fin_q && round_up) begin
			q_q <= q_q + QUO_W'(1);
		end
	end

	assign quot = q_q;
	assign done = done_q;
endmodule

// File: src/kalman_scalar_measurement_update_unit.sv
// top level of the scalar kalman measurement update unit (joseph form)
// The unit keeps a DIM x DIM error covariance P, a DIM error-state vector and
// a DIM measurement row H in synchronous rams, all signed fixed point with
// FRAC_BITS fraction bits in 48 bits. One item either writes or reads one
// entry, or runs a scalar update; every item returns exactly one result item.
// The pace of an update is set by the single shared multiplier, which
// builds each 48x48 product from four 24x24 partial products, and every
// multiply-accumulate walks read, multiply and accumulate through the rams
// one entry at a time; the gain and nis divisions run on a bit-serial
// divider. After reset the unit zeroes its covariance, measurement and
// error rams before it takes its first item. A result waits in an output
// register, so the next item can be taken while it waits.
module kalman_scalar_measurement_update_unit import ksu_pkg::*; #(
	parameter int DIM       = 15,
	parameter int FRAC_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	ksu_in_if.sink   in_ch,
	ksu_out_if.source out_ch
);
	localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int DEPTH2 = DIM * DIM;
	localparam int ADDR_W = (DEPTH2 > 1) ? $clog2(DEPTH2) : 1;
	localparam val_t QONE = VAL_W'(64'd1 << FRAC_BITS);
	localparam logic [5:0] DIM_L = 6'(DIM);

	ksu_state_t state_q, state_d;
	ksu_phase_t phase_q;

	// latched item
	ksu_func_t           func_q;
	logic [IN_IDX_W-1:0] row_q, col_q;
	val_t                wv_q, y_q;
	logic [NIS_W-1:0]    r_q;

	// loop counters and working registers
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic [ADDR_W-1:0] clr_q;
	acc_t              acc_q;
	val_t              a_q, kr_q, gq_q, err_new_q;
	logic [VAL_W-1:0]  s_q;
	logic              floored_q;
	logic [NIS_W-1:0]  nis_q;
	logic              nsat_q;

	// output register
	logic             out_valid_q;
	val_t             out_rd_q;
	logic [NIS_W-1:0] out_nis_q;
	logic             out_vf_q, out_ns_q;

	logic accept, out_free, load;
	logic i_last, j_last, k_last, clr_last, row_ok, col_ok;
	logic [ADDR_W-1:0] op_addr, ij_addr, kj_addr, ik_addr;

	// ram ports
	logic cov_we, h_we, err_we, gain_we, prod_we;
	logic [ADDR_W-1:0] cov_waddr, cov_raddr, prod_waddr, prod_raddr;
	logic [IDX_W-1:0]  h_waddr, h_raddr, err_waddr, err_raddr, gain_waddr, gain_raddr;
	val_t cov_wdata, h_wdata, err_wdata, gain_wdata, prod_wdata;
	val_t cov_rd, h_rd, err_rd, gain_rd, prod_rd;

	// shared arithmetic units
	logic              mul_start, mul_done;
	val_t              mul_a, mul_b, mul_q;
	logic [PROD_W-1:0] mul_prod;
	logic              div_start, div_done;
	logic [PROD_W-1:0] div_dvd;
	logic [QUO_W-1:0]  div_quot;

	logic signed [VAL_W:0] innov;
	val_t s_sat, a_new;
	logic delta;

	assign accept   = in_ch.valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ch.ready;
	assign load     = ((state_q == ST_OP_END) || (state_q == ST_RESULT)) && out_free;

	assign i_last   = (i_q == IDX_W'(DIM - 1));
	assign j_last   = (j_q == IDX_W'(DIM - 1));
	assign k_last   = (k_q == IDX_W'(DIM - 1));
	assign clr_last = (clr_q == ADDR_W'(DEPTH2 - 1));
	assign row_ok   = {2'b00, row_q} < DIM_L;
	assign col_ok   = {2'b00, col_q} < DIM_L;

	// flat addresses into the DIM x DIM stores
	assign op_addr = ADDR_W'(row_q) * ADDR_W'(DIM) + ADDR_W'(col_q);
	assign ij_addr = ADDR_W'(i_q) * ADDR_W'(DIM) + ADDR_W'(j_q);
	assign kj_addr = ADDR_W'(k_q) * ADDR_W'(DIM) + ADDR_W'(j_q);
	assign ik_addr = ADDR_W'(i_q) * ADDR_W'(DIM) + ADDR_W'(k_q);

	// innovation y = z - h, saturated
	assign innov = {in_ch.meas_value[VAL_W-1], in_ch.meas_value}
		- {in_ch.predicted_value[VAL_W-1], in_ch.predicted_value};

	// saturated accumulator; at the variance floor anything not above zero becomes one lsb
	assign s_sat = sat_acc(acc_q);

	// one entry of I - K H, kronecker term on the diagonal
	assign delta = (phase_q == PH_PROD) ? (i_q == k_q) : (j_q == k_q);
	assign a_new = sat_acc((delta ? acc_t'(QONE) : acc_t'(0)) - acc_t'(mul_q));

	ksu_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH2)) u_cov_ram (
		.clk(clk), .we(cov_we), .waddr(cov_waddr), .wdata(cov_wdata),
		.raddr(cov_raddr), .rdata(cov_rd)
	);
	ksu_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH2)) u_prod_ram (
		.clk(clk), .we(prod_we), .waddr(prod_waddr), .wdata(prod_wdata),
		.raddr(prod_raddr), .rdata(prod_rd)
	);
	ksu_ram #(.WIDTH(VAL_W), .DEPTH(DIM)) u_meas_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rd)
	);
	ksu_ram #(.WIDTH(VAL_W), .DEPTH(DIM)) u_err_ram (
		.clk(clk), .we(err_we), .waddr(err_waddr), .wdata(err_wdata),
		.raddr(err_raddr), .rdata(err_rd)
	);
	ksu_ram #(.WIDTH(VAL_W), .DEPTH(DIM)) u_gain_ram (
		.clk(clk), .we(gain_we), .waddr(gain_waddr), .wdata(gain_wdata),
		.raddr(gain_raddr), .rdata(gain_rd)
	);

	ksu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod), .qres(mul_q)
	);

	ksu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(s_q), .done(div_done), .quot(div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:    if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = (in_ch.func == FN_UPDATE) ? ST_RD : ST_OP_RD;
				end
			end
			ST_OP_RD:    state_d = ST_OP_END;
			ST_OP_END:   if (out_free) state_d = ST_IDLE;
			ST_RD:       state_d = (phase_q == PH_KDIV) ? ST_DIV : ST_MUL1;
			ST_MUL1:     state_d = ST_WAIT1;
			ST_WAIT1: begin
				if (mul_done) begin
					if (phase_q == PH_PROD || phase_q == PH_COV) state_d = ST_MUL2;
					else if (phase_q == PH_NIS) state_d = ST_DIV;
					else state_d = ST_NEXT;
				end
			end
			ST_MUL2:     state_d = ST_WAIT2;
			ST_WAIT2: begin
				if (mul_done) begin
					state_d = (phase_q == PH_COV && k_last) ? ST_KR_RD : ST_NEXT;
				end
			end
			ST_KR_RD:    state_d = ST_KR_MUL;
			ST_KR_MUL:   state_d = ST_KR_WAIT;
			ST_KR_WAIT:  if (mul_done) state_d = ST_KG_RD;
			ST_KG_RD:    state_d = ST_KG_MUL;
			ST_KG_MUL:   state_d = ST_KG_WAIT;
			ST_KG_WAIT:  if (mul_done) state_d = ST_NEXT;
			ST_DIV:      state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) state_d = (phase_q == PH_NIS) ? ST_RESULT : ST_NEXT;
			end
			ST_NEXT:     state_d = ST_RD;
			ST_RESULT:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_CLEAR;
		endcase
	end

	// ram control and arithmetic unit operands
	always_comb begin
		cov_we = 1'b0; h_we = 1'b0; err_we = 1'b0; gain_we = 1'b0; prod_we = 1'b0;
		cov_waddr = ij_addr;
		cov_wdata = s_sat;
		h_waddr = IDX_W'(col_q);
		h_wdata = wv_q;
		err_waddr = i_q;
		err_wdata = err_new_q;
		gain_waddr = i_q;
		gain_wdata = (phase_q == PH_KDIV) ? gq_q : s_sat;
		prod_waddr = ij_addr;
		prod_wdata = s_sat;

		cov_raddr = (phase_q == PH_GAIN) ? ij_addr : kj_addr;
		prod_raddr = ik_addr;
		err_raddr = i_q;
		case (phase_q)
			PH_GAIN: h_raddr = j_q;
			PH_VAR:  h_raddr = i_q;
			default: h_raddr = k_q;
		endcase
		// in the covariance pass the gain read is K_j, except while forming K_i * R
		gain_raddr = (phase_q == PH_COV && state_q != ST_KR_RD && state_q != ST_KR_MUL)
			? j_q : i_q;

		mul_start = 1'b0;
		mul_a = cov_rd;
		mul_b = h_rd;
		div_start = 1'b0;
		div_dvd = (phase_q == PH_NIS) ? mul_prod : (PROD_W'(mag(gain_rd)) << FRAC_BITS);

		unique case (state_q)
			ST_CLEAR: begin
				cov_we = 1'b1;
				cov_waddr = clr_q;
				cov_wdata = '0;
				h_we = (clr_q < ADDR_W'(DIM));
				h_waddr = IDX_W'(clr_q);
				h_wdata = '0;
				err_we = (clr_q < ADDR_W'(DIM));
				err_waddr = IDX_W'(clr_q);
				err_wdata = '0;
			end
			ST_OP_RD, ST_OP_END: begin
				cov_raddr = op_addr;
				err_raddr = IDX_W'(row_q);
				if (state_q == ST_OP_RD) begin
					cov_we = (func_q == FN_WR_COV) && row_ok && col_ok;
					cov_waddr = op_addr;
					cov_wdata = wv_q;
					h_we = (func_q == FN_WR_MEAS) && col_ok;
					err_we = (func_q == FN_WR_ERR) && row_ok;
					err_waddr = IDX_W'(row_q);
					err_wdata = wv_q;
				end
			end
			ST_MUL1: begin
				mul_start = 1'b1;
				case (phase_q)
					PH_GAIN: begin mul_a = cov_rd;  mul_b = h_rd;    end
					PH_VAR:  begin mul_a = h_rd;    mul_b = gain_rd; end
					PH_ERR:  begin mul_a = gain_rd; mul_b = y_q;     end
					PH_NIS:  begin mul_a = y_q;     mul_b = y_q;     end
					default: begin mul_a = gain_rd; mul_b = h_rd;    end
				endcase
			end
			ST_MUL2: begin
				mul_start = 1'b1;
				if (phase_q == PH_PROD) begin
					mul_a = a_q;
					mul_b = cov_rd;
				end else begin
					mul_a = prod_rd;
					mul_b = a_q;
				end
			end
			ST_KR_MUL: begin
				mul_start = 1'b1;
				mul_a = gain_rd;
				mul_b = val_t'({1'b0, r_q});
			end
			ST_KG_MUL: begin
				mul_start = 1'b1;
				mul_a = kr_q;
				mul_b = gain_rd;
			end
			ST_DIV: div_start = 1'b1;
			ST_NEXT: begin
				case (phase_q)
					PH_GAIN: gain_we = j_last;
					PH_KDIV: gain_we = 1'b1;
					PH_ERR:  err_we = 1'b1;
					PH_PROD: prod_we = k_last;
					PH_COV:  cov_we = k_last;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= PH_GAIN;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;

			if (accept) begin
				phase_q <= PH_GAIN;
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (state_q == ST_NEXT) begin
				case (phase_q)
					PH_GAIN: begin
						if (j_last) begin
							j_q <= '0;
							if (i_last) begin
								i_q <= '0;
								phase_q <= PH_VAR;
							end else i_q <= i_q + IDX_W'(1);
						end else j_q <= j_q + IDX_W'(1);
					end
					PH_VAR, PH_KDIV, PH_ERR: begin
						if (i_last) begin
							i_q <= '0;
							j_q <= '0;
							k_q <= '0;
							case (phase_q)
								PH_VAR:  phase_q <= PH_KDIV;
								PH_KDIV: phase_q <= PH_ERR;
								default: phase_q <= PH_PROD;
							endcase
						end else i_q <= i_q + IDX_W'(1);
					end
					PH_PROD, PH_COV: begin
						// k innermost, then column j, then row i
						if (k_last) begin
							k_q <= '0;
							if (j_last) begin
								j_q <= '0;
								if (i_last) begin
									i_q <= '0;
									phase_q <= (phase_q == PH_PROD) ? PH_COV : PH_NIS;
								end else i_q <= i_q + IDX_W'(1);
							end else j_q <= j_q + IDX_W'(1);
						end else k_q <= k_q + IDX_W'(1);
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= ksu_func_t'(in_ch.func);
			row_q     <= in_ch.row_index;
			col_q     <= in_ch.col_index;
			wv_q      <= in_ch.write_value;
			r_q       <= in_ch.noise_var;
			y_q       <= sat_acc(acc_t'(innov));
			acc_q     <= '0;
			floored_q <= 1'b0;
		end

		case (state_q)
			ST_WAIT1: begin
				if (mul_done) begin
					case (phase_q)
						PH_GAIN, PH_VAR: acc_q <= acc_q + acc_t'(mul_q);
						PH_ERR:  err_new_q <= sat_acc(acc_t'(err_rd) + acc_t'(mul_q));
						PH_PROD, PH_COV: a_q <= a_new;
						default: ;
					endcase
				end
			end
			ST_WAIT2:   if (mul_done) acc_q <= acc_q + acc_t'(mul_q);
			ST_KR_WAIT: if (mul_done) kr_q <= mul_q;
			// add K R K' on top of the saturated joseph product
			ST_KG_WAIT: if (mul_done) acc_q <= acc_t'(s_sat) + acc_t'(mul_q);
			ST_DIV_WAIT: begin
				if (div_done) begin
					if (phase_q == PH_NIS) begin
						nsat_q <= |div_quot[QUO_W-1:NIS_W];
						nis_q  <= (|div_quot[QUO_W-1:NIS_W]) ? {NIS_W{1'b1}}
							: div_quot[NIS_W-1:0];
					end else begin
						gq_q <= sat_mag((PROD_W+1)'(div_quot), gain_rd[VAL_W-1]);
					end
				end
			end
			ST_NEXT: begin
				case (phase_q)
					PH_GAIN: begin
						if (j_last) acc_q <= i_last ? acc_t'(r_q) : '0;
					end
					PH_VAR: begin
						if (i_last) begin
							if (s_sat < val_t'(1)) begin
								s_q <= VAL_W'(1);
								floored_q <= 1'b1;
							end else s_q <= VAL_W'(s_sat);
						end
					end
					PH_ERR:  if (i_last) acc_q <= '0;
					PH_PROD, PH_COV: if (k_last) acc_q <= '0;
					default: ;
				endcase
			end
			default: ;
		endcase

		if (load) begin
			out_rd_q  <= '0;
			out_nis_q <= '0;
			out_vf_q  <= 1'b0;
			out_ns_q  <= 1'b0;
			if (state_q == ST_RESULT) begin
				out_nis_q <= nis_q;
				out_vf_q  <= floored_q;
				out_ns_q  <= nsat_q;
			end else if (func_q == FN_RD_COV && row_ok && col_ok) begin
				out_rd_q <= cov_rd;
			end else if (func_q == FN_RD_ERR && row_ok) begin
				out_rd_q <= err_rd;
			end
		end
	end

	assign in_ch.ready          = (state_q == ST_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.read_data     = out_rd_q;
	assign out_ch.nis           = out_nis_q;
	assign out_ch.var_floored   = out_vf_q;
	assign out_ch.nis_saturated = out_ns_q;
endmodule

// File: src/ksu_checker.sv
// port-level checks of the scalar measurement update unit, bound to the top level
module ksu_checker import ksu_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [VAL_W-1:0] out_read_data,
	input logic [NIS_W-1:0] out_nis,
	input logic             out_var_floored,
	input logic             out_nis_saturated
);
	// a held result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_nis))
		else $error("held result changed");

	// one item at a time: no back-to-back accepts
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// a saturated nis reads as all ones
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_nis_saturated |-> out_nis == {NIS_W{1'b1}})
		else $error("saturated nis not at maximum");

	// read data and update fields never show together
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_read_data != '0) |->
			(out_nis == '0) && !out_var_floored && !out_nis_saturated)
		else $error("read result carries update fields");
endmodule

bind kalman_scalar_measurement_update_unit ksu_checker u_ksu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_read_data(out_ch.read_data),
	.out_nis(out_ch.nis),
	.out_var_floored(out_ch.var_floored),
	.out_nis_saturated(out_ch.nis_saturated)
);
